// ===== hdl/sample_address_histogram_top_assert.svh =====
// assertion macros for the sample address histogram
// used by files that include it by name, expects clk and rst_n in scope
`ifndef SAMPLE_ADDRESS_HISTOGRAM_TOP_ASSERT_SVH
`define SAMPLE_ADDRESS_HISTOGRAM_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SAH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sample address histogram check failed");
`define SAH_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample address histogram check failed");
`else
`define SAH_ASSERT(label, prop)
`define SAH_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

// ===== hdl/sah_pkg.sv =====
// shared types, constants and helper functions of the sample address histogram
// no dependencies
package sah_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int ADDR_W = 64;
    localparam int COUNT_W = 32;
    localparam int SLOT_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_HIT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_READ = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [COUNT_W-1:0] count;
    } entry_t;

    function automatic logic [ADDR_W-1:0] sat_inc64(input logic [ADDR_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ===== hdl/sah_in_if.sv =====
// request channel of the sample address histogram
// depends on sah_pkg
interface sah_in_if;
    logic valid;
    logic ready;
    logic func;
    logic [sah_pkg::ADDR_W-1:0] sample_address;
    logic [sah_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, func, sample_address, slot_index, input ready);
    modport sink (input valid, func, sample_address, slot_index, output ready);
endinterface

// ===== hdl/sah_out_if.sv =====
// result channel of the sample address histogram
// depends on sah_pkg
interface sah_out_if;
    logic valid;
    logic ready;
    logic [sah_pkg::STATUS_W-1:0] status;
    logic [sah_pkg::SLOT_W-1:0] slot;
    logic [sah_pkg::ADDR_W-1:0] entry_address;
    logic [sah_pkg::COUNT_W-1:0] entry_count;
    logic [sah_pkg::ADDR_W-1:0] total_samples;
    logic [sah_pkg::ADDR_W-1:0] dropped_samples;

    modport source (output valid, status, slot, entry_address, entry_count,
                    total_samples, dropped_samples, input ready);
    modport sink (input valid, status, slot, entry_address, entry_count,
                  total_samples, dropped_samples, output ready);
endinterface

// ===== hdl/sample_address_histogram_top.sv =====
// sample address histogram: counts sampled addresses in a linear-probing table
// depends on sah_pkg, sah_in_if, sah_out_if, sah_hash, sah_table and the assert header
//
// usage:
//   sample: request channel, func 0 records sample_address, func 1 reads the
//           slot named by slot_index (wrapped to the table size)
//   result: one transaction per request with status, slot, slot contents and
//           the total and dropped counters after the request
// sequencing:
//   after reset a clearing pass writes every slot, during which sample.ready
//   stays low; counters reset at once
//   a read passes through the READ and CHECK states before its result is registered
//   a record first runs the hash, then a READ and a CHECK state per probe;
//   the hash uses one 32x32 multiplier four times and each probe waits on the
//   table read port
//   address zero is hashed too and then reports slot 0 unchanged
// flow control:
//   one request at a time; a new request is taken once the previous one has
//   produced its result, even while that result waits in the output register
//   a stalled result holds the block in its final check until taken
`include "sample_address_histogram_top_assert.svh"

module sample_address_histogram_top #(
    parameter int INDEX_BITS = sah_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sah_in_if.sink      sample,
    sah_out_if.source   result
);
    import sah_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_reg, clr_next;
    logic [INDEX_BITS-1:0] probe_idx_reg, probe_idx_next;
    logic [INDEX_BITS-1:0] probe_cnt_reg, probe_cnt_next;
    logic func_reg, func_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] total_reg, total_next;
    logic [ADDR_W-1:0] dropped_reg, dropped_next;

    logic res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    entry_t res_entry_reg, res_entry_next;
    logic [ADDR_W-1:0] res_total_reg, res_total_next;
    logic [ADDR_W-1:0] res_dropped_reg, res_dropped_next;

    logic hash_start;
    logic hash_done;
    logic [INDEX_BITS-1:0] hash_idx;

    logic rd_en;
    entry_t rd_entry;
    logic wr_en;
    logic [INDEX_BITS-1:0] wr_idx;
    entry_t wr_entry;

    logic accept;
    logic out_free;
    logic emit;
    logic [STATUS_W-1:0] emit_status;
    entry_t emit_entry;
    logic [31:0] emit_slot_wide;
    logic [31:0] req_slot_wide;
    logic [31:0] probe_slot_wide;

    sah_hash #(.INDEX_BITS(INDEX_BITS)) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .address (sample.sample_address),
        .done    (hash_done),
        .index   (hash_idx)
    );

    sah_table #(.INDEX_BITS(INDEX_BITS)) u_table (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_idx   (probe_idx_reg),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    assign accept = sample.valid && sample.ready;
    assign out_free = !res_valid_reg || result.ready;
    assign req_slot_wide = 32'(sample.slot_index);
    assign probe_slot_wide = 32'(probe_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        probe_idx_next = probe_idx_reg;
        probe_cnt_next = probe_cnt_reg;
        func_next = func_reg;
        addr_next = addr_reg;
        total_next = total_reg;
        dropped_next = dropped_reg;
        hash_start = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        wr_idx = probe_idx_reg;
        wr_entry = '0;
        emit = 1'b0;
        emit_status = STATUS_HIT;
        emit_entry = rd_entry;
        emit_slot_wide = probe_slot_wide;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_idx = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = sample.func;
                    addr_next = sample.sample_address;
                    probe_cnt_next = '0;
                    if (sample.func == FUNC_READ)
                    begin
                        probe_idx_next = req_slot_wide[INDEX_BITS-1:0];
                        state_next = ST_READ;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    probe_idx_next = hash_idx;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (func_reg == FUNC_READ)
                begin
                    emit = out_free;
                    emit_status = STATUS_READ;
                end
                else if (addr_reg == '0)
                begin
                    emit = out_free;
                    emit_status = STATUS_HIT;
                    if (out_free)
                    begin
                        total_next = sat_inc64(total_reg);
                    end
                end
                else if (rd_entry.address == addr_reg)
                begin
                    emit = out_free;
                    emit_status = STATUS_HIT;
                    wr_entry.address = addr_reg;
                    wr_entry.count = sat_inc32(rd_entry.count);
                    emit_entry = wr_entry;
                    if (out_free)
                    begin
                        wr_en = 1'b1;
                        total_next = sat_inc64(total_reg);
                    end
                end
                else if (rd_entry.address == '0)
                begin
                    emit = out_free;
                    emit_status = STATUS_NEW;
                    wr_entry.address = addr_reg;
                    wr_entry.count = COUNT_W'(1);
                    emit_entry = wr_entry;
                    if (out_free)
                    begin
                        wr_en = 1'b1;
                        total_next = sat_inc64(total_reg);
                    end
                end
                else if (probe_cnt_reg == '1)
                begin
                    emit = out_free;
                    emit_status = STATUS_DROP;
                    emit_entry = '0;
                    emit_slot_wide = '0;
                    if (out_free)
                    begin
                        dropped_next = sat_inc64(dropped_reg);
                    end
                end
                else
                begin
                    probe_idx_next = probe_idx_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next = ST_READ;
                end
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = res_valid_reg && !result.ready;
        res_status_next = res_status_reg;
        res_slot_next = res_slot_reg;
        res_entry_next = res_entry_reg;
        res_total_next = res_total_reg;
        res_dropped_next = res_dropped_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_status_next = emit_status;
            res_slot_next = emit_slot_wide[SLOT_W-1:0];
            res_entry_next = emit_entry;
            res_total_next = total_next;
            res_dropped_next = dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            total_reg <= '0;
            dropped_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            total_reg <= total_next;
            dropped_reg <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_idx_reg <= probe_idx_next;
        probe_cnt_reg <= probe_cnt_next;
        func_reg <= func_next;
        addr_reg <= addr_next;
        res_status_reg <= res_status_next;
        res_slot_reg <= res_slot_next;
        res_entry_reg <= res_entry_next;
        res_total_reg <= res_total_next;
        res_dropped_reg <= res_dropped_next;
    end

    assign sample.ready = (state_reg == ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.status = res_status_reg;
    assign result.slot = res_slot_reg;
    assign result.entry_address = res_entry_reg.address;
    assign result.entry_count = res_entry_reg.count;
    assign result.total_samples = res_total_reg;
    assign result.dropped_samples = res_dropped_reg;

    `SAH_ASSERT_IMPLIES(a_write_state, wr_en, (state_reg == ST_CLEAR) || (state_reg == ST_CHECK))
    `SAH_ASSERT_IMPLIES(a_hash_done_state, hash_done, state_reg == ST_HASH)
    `SAH_ASSERT(a_one_counter, 1'b1 |=> ($stable(total_reg) || $stable(dropped_reg)))
    `SAH_ASSERT_IMPLIES(a_no_result_in_clear, state_reg == ST_CLEAR, !res_valid_reg)

endmodule

// ===== hdl/sah_hash.sv =====
// fibonacci hash: 64-bit product modulo 2^64 from one shared 32x32 multiplier
// over four steps, index taken from the top bits; depends on sah_pkg
module sah_hash #(
    parameter int INDEX_BITS = sah_pkg::INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sah_pkg::ADDR_W-1:0]  address,
    output logic                        done,
    output logic [INDEX_BITS-1:0]       index
);
    import sah_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] prod_reg;
    logic [1:0] step_reg;
    logic busy_reg;
    logic done_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [ADDR_W-1:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_a = addr_reg[31:0];
                op_b = FIB_MULT[31:0];
            end
            2'd1:
            begin
                op_a = addr_reg[63:32];
                op_b = FIB_MULT[31:0];
            end
            default:
            begin
                op_a = addr_reg[31:0];
                op_b = FIB_MULT[63:32];
            end
        endcase
    end

    assign prod = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // cross terms only reach the upper half of the product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= address;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod;
            case (step_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                2'd3:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done = done_reg;
    assign index = acc_reg[ADDR_W-1 -: INDEX_BITS];

endmodule

// ===== hdl/sah_table.sv =====
// slot table: one write port and one registered read port
// depends on sah_pkg
module sah_table #(
    parameter int INDEX_BITS = sah_pkg::INDEX_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [INDEX_BITS-1:0]   rd_idx,
    output sah_pkg::entry_t         rd_entry,
    input  logic                    wr_en,
    input  logic [INDEX_BITS-1:0]   wr_idx,
    input  sah_pkg::entry_t         wr_entry
);
    import sah_pkg::*;

    entry_t mem [2**INDEX_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry <= mem[rd_idx];
        end
    end

endmodule
